>>> sv/emrr_pkg.sv
// Shared types, register codes and PHY table for the Ethernet MAC ring controller.
package emrr_pkg;

   localparam int RING_ENTRIES_DEFAULT = 128;

   typedef enum logic [1:0] {
      ACT_REG_WRITE = 2'd0,
      ACT_REG_READ  = 2'd1,
      ACT_TX_TICK   = 2'd2,
      ACT_RX_FRAME  = 2'd3
   } action_type;

   // Register select codes, taken from reg_offset bits 7:2
   localparam logic [5:0] REG_CONTROL = 6'h00;
   localparam logic [5:0] REG_STATUS  = 6'h01;
   localparam logic [5:0] REG_MAC_HI  = 6'h02;
   localparam logic [5:0] REG_MAC_LO  = 6'h03;
   localparam logic [5:0] REG_MDIO    = 6'h04;
   localparam logic [5:0] REG_TX_PTR  = 6'h05;
   localparam logic [5:0] REG_RX_PTR  = 6'h06;

   localparam int CTRL_TX_EN     = 0;
   localparam int CTRL_RX_EN     = 1;
   localparam int CTRL_TX_IRQ_EN = 2;
   localparam int CTRL_RX_IRQ_EN = 3;
   localparam int CTRL_RESET     = 6;
   localparam logic [31:0] CTRL_RESET_VALUE = 32'h0000_0080;

   localparam int STAT_RX_DONE = 2;
   localparam int STAT_TX_DONE = 3;

   localparam int DESC_EN       = 11;
   localparam int DESC_RING_END = 12;
   localparam int DESC_IRQ      = 13;

   localparam int MDIO_WR = 0;
   localparam int MDIO_RD = 1;

   localparam logic [47:0] BCAST_ADDR = 48'hffff_ffff_ffff;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  reg_offset;
      logic [31:0] write_data;
      logic [31:0] desc_word;
      logic [47:0] frame_dest;
      logic [10:0] frame_len;
   } req_item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq;
      logic        desc_write;
      logic [31:0] desc_addr;
      logic [10:0] desc_data;
      logic        frame_go;
      logic        frame_drop;
      logic        link_start;
   } rsp_item_type;

   function automatic logic [15:0] phy_value(input logic [4:0] phy_reg);
      logic [15:0] val;
      unique case (phy_reg)
         5'd0:    val = 16'h3100;
         5'd1:    val = 16'h7865;
         5'd2:    val = 16'h0022;
         5'd3:    val = 16'h1512;
         5'd4:    val = 16'h01ef;
         5'd5:    val = 16'h41e1;
         default: val = 16'h0000;
      endcase
      return val;
   endfunction

endpackage

>>> sv/ethernet_mac_register_ring_ctrl_top.sv
// Ethernet MAC register file with transmit and receive descriptor ring control.
// A result beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one request beat per cycle; the single result register stalls input
// only while a result beat waits and rsp_ready is low.
// Reset (synchronous, active high) clears all register-file registers, ring pointers, the link
// started flag and the result valid.
module ethernet_mac_register_ring_ctrl_top
   import emrr_pkg::*;
#(
   parameter int RING_ENTRIES = RING_ENTRIES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data
);

   localparam int IDX_W = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_ENTRIES - 1);

   logic [31:0] control_ff, control_in;
   logic [3:0]  status_ff, status_in;
   logic [15:0] mac_high_ff, mac_high_in;
   logic [31:0] mac_low_ff, mac_low_in;
   logic [31:0] mdio_ff, mdio_in;
   logic [31:0] tx_ptr_ff, tx_ptr_in;
   logic [31:0] rx_ptr_ff, rx_ptr_in;
   logic        link_started_ff, link_started_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;

   logic        req_fire;
   logic [5:0]  sel;
   logic        addr_match;
   logic [31:0] tx_ptr_next, rx_ptr_next;

   function automatic logic [31:0] ring_advance(input logic [31:0] ptr, input logic wrap);
      logic [31:0] res;
      res = ptr + 32'd8;
      if (wrap || (ptr[IDX_W+2:3] >= IDX_LAST)) begin
         res = ptr;
         res[IDX_W+2:3] = '0;
      end
      return res;
   endfunction

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign sel         = req_data.reg_offset[7:2];
   assign addr_match  = (req_data.frame_dest == {mac_high_ff, mac_low_ff}) ||
                        (req_data.frame_dest == BCAST_ADDR);
   assign tx_ptr_next = ring_advance(tx_ptr_ff, req_data.desc_word[DESC_RING_END]);
   assign rx_ptr_next = ring_advance(rx_ptr_ff, req_data.desc_word[DESC_RING_END]);

   always_comb begin
      control_in      = control_ff;
      status_in       = status_ff;
      mac_high_in     = mac_high_ff;
      mac_low_in      = mac_low_ff;
      mdio_in         = mdio_ff;
      tx_ptr_in       = tx_ptr_ff;
      rx_ptr_in       = rx_ptr_ff;
      link_started_in = link_started_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_data_in     = rsp_data_ff;

      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         unique case (action_type'(req_data.action))
            ACT_REG_WRITE: begin
               unique case (sel)
                  REG_CONTROL: begin
                     if (req_data.write_data[CTRL_RESET]) begin
                        control_in = CTRL_RESET_VALUE;
                     end else begin
                        // first receive enable hands the address to the link
                        if (req_data.write_data[CTRL_RX_EN] && !control_ff[CTRL_RX_EN] &&
                            !link_started_ff) begin
                           link_started_in        = 1'b1;
                           rsp_data_in.link_start = 1'b1;
                        end
                        control_in = req_data.write_data;
                     end
                  end
                  REG_STATUS: status_in   = status_ff & ~req_data.write_data[3:0];
                  REG_MAC_HI: mac_high_in = req_data.write_data[15:0];
                  REG_MAC_LO: mac_low_in  = req_data.write_data;
                  REG_MDIO: begin
                     if (!req_data.write_data[MDIO_WR] && req_data.write_data[MDIO_RD]) begin
                        mdio_in = {phy_value(req_data.write_data[10:6]), 16'h0000};
                     end else begin
                        mdio_in = {req_data.write_data[31:4], 4'h0};
                     end
                  end
                  REG_TX_PTR: tx_ptr_in = {req_data.write_data[31:3], 3'b000};
                  REG_RX_PTR: rx_ptr_in = {req_data.write_data[31:3], 3'b000};
                  default: ;
               endcase
            end
            ACT_REG_READ: begin
               unique case (sel)
                  REG_CONTROL: rsp_data_in.read_data = control_ff;
                  REG_STATUS:  rsp_data_in.read_data = {28'h0, status_ff};
                  REG_MAC_HI:  rsp_data_in.read_data = {16'h0, mac_high_ff};
                  REG_MAC_LO:  rsp_data_in.read_data = mac_low_ff;
                  REG_MDIO:    rsp_data_in.read_data = mdio_ff;
                  REG_TX_PTR:  rsp_data_in.read_data = tx_ptr_ff;
                  REG_RX_PTR:  rsp_data_in.read_data = rx_ptr_ff;
                  default:     rsp_data_in.read_data = '0;
               endcase
            end
            ACT_TX_TICK: begin
               if (link_started_ff && control_ff[CTRL_TX_EN]) begin
                  rsp_data_in.desc_addr = tx_ptr_ff;
                  if (req_data.desc_word[DESC_EN]) begin
                     status_in[STAT_TX_DONE] = 1'b1;
                     rsp_data_in.irq        = control_ff[CTRL_TX_IRQ_EN] &&
                                              req_data.desc_word[DESC_IRQ];
                     rsp_data_in.desc_write = 1'b1;
                     rsp_data_in.desc_data  = req_data.desc_word[10:0];
                     rsp_data_in.frame_go   = 1'b1;
                     tx_ptr_in              = tx_ptr_next;
                  end
               end
            end
            ACT_RX_FRAME: begin
               if (addr_match && control_ff[CTRL_RX_EN]) begin
                  rsp_data_in.desc_addr = rx_ptr_ff;
                  if (req_data.desc_word[DESC_EN]) begin
                     status_in[STAT_RX_DONE] = 1'b1;
                     rsp_data_in.irq        = control_ff[CTRL_RX_IRQ_EN] &&
                                              req_data.desc_word[DESC_IRQ];
                     rsp_data_in.desc_write = 1'b1;
                     rsp_data_in.desc_data  = req_data.frame_len;
                     rsp_data_in.frame_go   = 1'b1;
                     rx_ptr_in              = rx_ptr_next;
                  end else begin
                     rsp_data_in.frame_drop = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff      <= '0;
         status_ff       <= '0;
         mac_high_ff     <= '0;
         mac_low_ff      <= '0;
         mdio_ff         <= '0;
         tx_ptr_ff       <= '0;
         rx_ptr_ff       <= '0;
         link_started_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         control_ff      <= control_in;
         status_ff       <= status_in;
         mac_high_ff     <= mac_high_in;
         mac_low_ff      <= mac_low_in;
         mdio_ff         <= mdio_in;
         tx_ptr_ff       <= tx_ptr_in;
         rx_ptr_ff       <= rx_ptr_in;
         link_started_ff <= link_started_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // hold the result beat until it is taken
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_no_accept_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request accepted while result beat stalled");

   a_link_sticky: assert property (@(posedge clock) disable iff (reset)
      link_started_ff |=> link_started_ff)
      else $error("link started flag cleared");

   a_link_pulse_sets_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.link_start) |-> link_started_ff)
      else $error("link start pulse without link started flag");

   a_go_drop_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.frame_drop && rsp_data_ff.desc_write))
      else $error("frame both dropped and written back");

   a_ptr_aligned: assert property (@(posedge clock) disable iff (reset)
      (tx_ptr_ff[2:0] == 3'b000) && (rx_ptr_ff[2:0] == 3'b000))
      else $error("ring pointer not descriptor aligned");
`endif

endmodule

>>> verif/tb_ethernet_mac_register_ring_ctrl_top.sv
// Self-checking testbench for the Ethernet MAC register file and descriptor ring controller.
module tb_ethernet_mac_register_ring_ctrl_top;
   import emrr_pkg::*;

   localparam int RANDOM_ITEMS = 1850;
   localparam int STALL_LIMIT  = 2000;
   localparam int LONG_HOLD    = 300;
   localparam int TAIL_CYCLES  = 10;
   localparam logic [15:0] PHY_ID_TABLE [6] = '{16'h3100, 16'h7865, 16'h0022,
                                                16'h1512, 16'h01ef, 16'h41e1};

   // Mirror of the controller state; predicts one result beat per request beat.
   class mac_ring_mirror;
      logic [31:0]  control_reg;
      logic [3:0]   status_bits;
      logic [15:0]  mac_high;
      logic [31:0]  mac_low;
      logic [31:0]  mdio_reg;
      logic [31:0]  tx_ptr;
      logic [31:0]  rx_ptr;
      bit           link_started;
      rsp_item_type owed_rsp[$];
      int           error_count;
      int           rsp_count;
      int           action_count[4];
      int           tx_sent, rx_stored, rx_dropped, irq_count, wrap_count;

      function new();
         control_reg  = '0;
         status_bits  = '0;
         mac_high     = '0;
         mac_low      = '0;
         mdio_reg     = '0;
         tx_ptr       = '0;
         rx_ptr       = '0;
         link_started = 1'b0;
         error_count  = 0;
         rsp_count    = 0;
         action_count = '{0, 0, 0, 0};
         tx_sent      = 0;
         rx_stored    = 0;
         rx_dropped   = 0;
         irq_count    = 0;
         wrap_count   = 0;
      endfunction

      function int owed_count();
         return owed_rsp.size();
      endfunction

      // Index field spans ceil(log2(entries)) bits above the 8-byte descriptor step.
      function logic [31:0] ring_next(logic [31:0] ptr, logic [31:0] desc);
         logic [31:0] span;
         logic [31:0] mask;
         logic [31:0] idx;
         span = 32'd1;
         while (span < RING_ENTRIES_DEFAULT && span < 32'h1000_0000) span = span << 1;
         mask = (span - 32'd1) << 3;
         idx  = (ptr & mask) >> 3;
         if (desc[DESC_RING_END] || idx >= RING_ENTRIES_DEFAULT - 1) begin
            wrap_count++;
            return ptr & ~mask;
         end
         return ptr + 32'd8;
      endfunction

      function void note_request(req_item_type req);
         rsp_item_type predicted;
         logic [5:0]   sel;
         logic [31:0]  wd;
         logic [4:0]   phy_sel;
         logic [15:0]  phy_word;
         predicted = '0;
         sel       = req.reg_offset[7:2];
         wd        = req.write_data;
         action_count[req.action]++;
         case (action_type'(req.action))
            ACT_REG_WRITE: begin
               case (sel)
                  REG_CONTROL: begin
                     if (wd[CTRL_RESET]) begin
                        control_reg = CTRL_RESET_VALUE;
                     end else begin
                        if (wd[CTRL_RX_EN] && !control_reg[CTRL_RX_EN] && !link_started) begin
                           link_started         = 1'b1;
                           predicted.link_start = 1'b1;
                        end
                        control_reg = wd;
                     end
                  end
                  REG_STATUS: status_bits = status_bits & ~wd[3:0];
                  REG_MAC_HI: mac_high = wd[15:0];
                  REG_MAC_LO: mac_low = wd;
                  REG_MDIO: begin
                     mdio_reg = {wd[31:4], 4'h0};
                     // a read with no write flag latches the PHY register in the top half
                     if (!wd[MDIO_WR] && wd[MDIO_RD]) begin
                        phy_sel  = wd[10:6];
                        phy_word = (phy_sel < 5'd6) ? PHY_ID_TABLE[phy_sel] : 16'h0000;
                        mdio_reg = {phy_word, 16'h0000};
                     end
                  end
                  REG_TX_PTR: tx_ptr = {wd[31:3], 3'b000};
                  REG_RX_PTR: rx_ptr = {wd[31:3], 3'b000};
                  default: ;
               endcase
            end
            ACT_REG_READ: begin
               case (sel)
                  REG_CONTROL: predicted.read_data = control_reg;
                  REG_STATUS:  predicted.read_data = {28'h0, status_bits};
                  REG_MAC_HI:  predicted.read_data = {16'h0, mac_high};
                  REG_MAC_LO:  predicted.read_data = mac_low;
                  REG_MDIO:    predicted.read_data = mdio_reg;
                  REG_TX_PTR:  predicted.read_data = tx_ptr;
                  REG_RX_PTR:  predicted.read_data = rx_ptr;
                  default:     predicted.read_data = '0;
               endcase
            end
            ACT_TX_TICK: begin
               if (link_started && control_reg[CTRL_TX_EN]) begin
                  predicted.desc_addr = tx_ptr;
                  if (req.desc_word[DESC_EN]) begin
                     status_bits[STAT_TX_DONE] = 1'b1;
                     predicted.irq        = control_reg[CTRL_TX_IRQ_EN] && req.desc_word[DESC_IRQ];
                     predicted.desc_write = 1'b1;
                     predicted.desc_data  = req.desc_word[10:0];
                     predicted.frame_go   = 1'b1;
                     tx_ptr = ring_next(tx_ptr, req.desc_word);
                     tx_sent++;
                  end
               end
            end
            default: begin
               if ((req.frame_dest == {mac_high, mac_low} || req.frame_dest == BCAST_ADDR)
                   && control_reg[CTRL_RX_EN]) begin
                  predicted.desc_addr = rx_ptr;
                  if (req.desc_word[DESC_EN]) begin
                     status_bits[STAT_RX_DONE] = 1'b1;
                     predicted.irq        = control_reg[CTRL_RX_IRQ_EN] && req.desc_word[DESC_IRQ];
                     predicted.desc_write = 1'b1;
                     predicted.desc_data  = req.frame_len;
                     predicted.frame_go   = 1'b1;
                     rx_ptr = ring_next(rx_ptr, req.desc_word);
                     rx_stored++;
                  end else begin
                     predicted.frame_drop = 1'b1;
                     rx_dropped++;
                  end
               end
            end
         endcase
         if (predicted.irq) irq_count++;
         owed_rsp.push_back(predicted);
      endfunction

      task report(string what, logic [63:0] want, logic [63:0] seen);
         $display("mismatch at result %0d: %s wanted %0h got %0h", rsp_count, what, want, seen);
         error_count++;
      endtask

      task check_response(rsp_item_type got);
         rsp_item_type predicted;
         rsp_count++;
         if (owed_rsp.size() == 0) begin
            report("result beat with nothing outstanding", '0, got.desc_addr);
            return;
         end
         predicted = owed_rsp.pop_front();
         if (got.read_data !== predicted.read_data)
            report("read_data", predicted.read_data, got.read_data);
         if (got.irq !== predicted.irq) report("irq", predicted.irq, got.irq);
         if (got.desc_write !== predicted.desc_write)
            report("desc_write", predicted.desc_write, got.desc_write);
         if (got.desc_addr !== predicted.desc_addr)
            report("desc_addr", predicted.desc_addr, got.desc_addr);
         if (got.desc_data !== predicted.desc_data)
            report("desc_data", predicted.desc_data, got.desc_data);
         if (got.frame_go !== predicted.frame_go)
            report("frame_go", predicted.frame_go, got.frame_go);
         if (got.frame_drop !== predicted.frame_drop)
            report("frame_drop", predicted.frame_drop, got.frame_drop);
         if (got.link_start !== predicted.link_start)
            report("link_start", predicted.link_start, got.link_start);
      endtask
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_data;

   mac_ring_mirror mac_mirror = new();
   bit             hold_rsp   = 1'b0;
   int             sent_count = 0;
   int             quiet_cycles = 0;

   ethernet_mac_register_ring_ctrl_top #(
      .RING_ENTRIES(RING_ENTRIES_DEFAULT)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Alternate full idling, no idling and sparse idling in blocks of 50 beats.
   function automatic int pick_gap(int n);
      case ((n / 50) % 3)
         0:       return int'($urandom_range(0, 13));
         1:       return 0;
         default: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 13)) : 0;
      endcase
   endfunction

   function automatic req_item_type filler(action_type act);
      req_item_type item;
      item.action     = act;
      item.reg_offset = 8'($urandom);
      item.write_data = $urandom;
      item.desc_word  = $urandom;
      item.frame_dest = {16'($urandom), $urandom};
      item.frame_len  = 11'($urandom);
      return item;
   endfunction

   function automatic req_item_type make_write(logic [7:0] offset, logic [31:0] data);
      req_item_type item;
      item            = filler(ACT_REG_WRITE);
      item.reg_offset = offset;
      item.write_data = data;
      return item;
   endfunction

   function automatic req_item_type make_read(logic [7:0] offset);
      req_item_type item;
      item            = filler(ACT_REG_READ);
      item.reg_offset = offset;
      return item;
   endfunction

   function automatic req_item_type make_tick(logic [31:0] desc);
      req_item_type item;
      item           = filler(ACT_TX_TICK);
      item.desc_word = desc;
      return item;
   endfunction

   function automatic req_item_type make_frame(logic [47:0] dest, logic [10:0] len,
                                               logic [31:0] desc);
      req_item_type item;
      item            = filler(ACT_RX_FRAME);
      item.frame_dest = dest;
      item.frame_len  = len;
      item.desc_word  = desc;
      return item;
   endfunction

   function automatic req_item_type random_request();
      int          pick;
      logic [31:0] data;
      logic [31:0] desc;
      logic [47:0] dest;
      pick = $urandom_range(0, 99);
      data = $urandom;
      desc = $urandom;
      desc[DESC_EN]       = ($urandom_range(0, 4) != 0);
      desc[DESC_RING_END] = ($urandom_range(0, 9) == 0);
      if (pick < 10) begin
         // keep both directions enabled most of the time so the rings keep moving
         data[CTRL_RESET] = ($urandom_range(0, 19) == 0);
         data[CTRL_TX_EN] = ($urandom_range(0, 4) != 0);
         data[CTRL_RX_EN] = ($urandom_range(0, 4) != 0);
         return make_write({REG_CONTROL, 2'($urandom)}, data);
      end else if (pick < 15) begin
         return make_write({REG_STATUS, 2'($urandom)}, data);
      end else if (pick < 20) begin
         return make_write({($urandom_range(0, 1) ? REG_MAC_HI : REG_MAC_LO), 2'($urandom)}, data);
      end else if (pick < 25) begin
         if ($urandom_range(0, 1)) data[10:6] = 5'($urandom_range(0, 6));
         return make_write({REG_MDIO, 2'($urandom)}, data);
      end else if (pick < 30) begin
         // land near the end of a 128-entry ring half the time
         if ($urandom_range(0, 1)) data[9:3] = 7'($urandom_range(120, 127));
         return make_write({($urandom_range(0, 1) ? REG_TX_PTR : REG_RX_PTR), 2'($urandom)}, data);
      end else if (pick < 32) begin
         return make_write({6'($urandom_range(7, 63)), 2'($urandom)}, data);
      end else if (pick < 45) begin
         if ($urandom_range(0, 2) == 0) return make_read(8'($urandom));
         return make_read({6'($urandom_range(0, 6)), 2'($urandom)});
      end else if (pick < 70) begin
         return make_tick(desc);
      end
      case ($urandom_range(0, 3))
         0, 1:    dest = {mac_mirror.mac_high, mac_mirror.mac_low};
         2:       dest = BCAST_ADDR;
         default: dest = {16'($urandom), $urandom};
      endcase
      return make_frame(dest, 11'($urandom), desc);
   endfunction

   // Hold valid and payload until the beat is taken.
   task automatic send_request(input req_item_type item);
      int gap;
      gap = pick_gap(sent_count);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      sent_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (mac_mirror.owed_count() != 0);
   endtask

   // Sample both channels once per edge so prediction and checking see one order.
   always @(posedge clock) begin
      if (req_valid === 1'b1 && req_ready === 1'b1) mac_mirror.note_request(req_data);
      if (rsp_valid === 1'b1 && rsp_ready === 1'b1) mac_mirror.check_response(rsp_data);
      if ((req_valid === 1'b1 && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result side: random back-pressure plus one long hold-off on request.
   initial begin
      int gap;
      int taken;
      taken = 0;
      forever begin
         gap = pick_gap(taken);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            gap      = LONG_HOLD;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         taken++;
      end
   end

   initial begin
      logic [47:0] station;
      station = 48'ha1b2_0000_0000;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_request(make_write(8'h00, 32'h0000_0005));       // tx on, link not started
      send_request(make_tick(32'hffff_ffff));               // drop: link not started
      send_request(make_write(8'h08, 32'hffff_a1b2));
      send_request(make_write(8'h0c, 32'h0000_0000));
      send_request(make_write(8'h18, 32'h0000_03f7));       // rx index 126
      send_request(make_write(8'h14, 32'hffff_ffff));       // tx index 127
      send_request(make_write(8'h00, 32'h0000_000f));       // first rx enable starts link
      send_request(make_tick(32'h0000_2fff));               // wraps at last entry
      send_request(make_tick(32'h0000_0000));
      send_request(make_frame(station, 11'h7ff, 32'h0000_2800));
      send_request(make_frame(BCAST_ADDR, 11'h000, 32'h0000_0800));
      send_request(make_frame(BCAST_ADDR, 11'h155, 32'h0000_1800));
      send_request(make_frame(48'h0000_0000_0001, 11'h2aa, 32'hffff_ffff));
      send_request(make_frame(BCAST_ADDR, 11'h7ff, 32'hffff_f7ff));
      send_request(make_read(8'h04));
      send_request(make_write(8'h07, 32'h0000_0004));       // clear rx done only
      send_request(make_write(8'h10, 32'h0000_0142));       // phy read of register 5
      send_request(make_read(8'h13));
      send_request(make_write(8'h10, 32'hffff_ffff));
      send_request(make_write(8'hfc, 32'hffff_ffff));
      send_request(make_read(8'hff));
      send_request(make_write(8'h00, 32'h0000_0040));       // control reset value
      send_request(make_tick(32'h0000_0800));               // drop: tx disabled
      send_request(make_read(8'h00));
      send_request(make_write(8'h00, 32'h0000_0002));       // no second link pulse

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == 300) hold_rsp = 1'b1;
         if (k == 900) wait_drained();
         send_request(random_request());
      end
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d writes, %0d reads, %0d tx ticks, %0d frame arrivals",
               mac_mirror.action_count[ACT_REG_WRITE], mac_mirror.action_count[ACT_REG_READ],
               mac_mirror.action_count[ACT_TX_TICK], mac_mirror.action_count[ACT_RX_FRAME]);
      $display("%0d sent, %0d stored, %0d dropped, %0d irqs, %0d ring wraps, %0d mismatches",
               mac_mirror.tx_sent, mac_mirror.rx_stored, mac_mirror.rx_dropped,
               mac_mirror.irq_count, mac_mirror.wrap_count, mac_mirror.error_count);
      if (mac_mirror.error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> filelist.f
sv/emrr_pkg.sv
sv/ethernet_mac_register_ring_ctrl_top.sv
verif/tb_ethernet_mac_register_ring_ctrl_top.sv
